@@ hw/rtl/bpa_pkg.sv @@
package bpa_pkg;

	// Fixed field widths
	localparam int REQ_W  = 20;
	localparam int PIDX_W = 10;
	localparam int ST_W   = 2;
	localparam int ORD_W  = 4;

	// Default configuration
	localparam int NUM_ORDERS_DEF      = 11;
	localparam int PAGE_BYTES_LOG2_DEF = 10;
	localparam int HEADER_BYTES_DEF    = 16;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_NOMEM   = 2'd1;
	localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

	// Datapath operations, one per controller step
	typedef enum logic [4:0] {
		OP_NOP,
		OP_CLEAR,
		OP_LOAD,
		OP_SEARCH,
		OP_POP,
		OP_POP_WR,
		OP_SPLIT,
		OP_FREE_CHK,
		OP_BUD_RD,
		OP_BUD_CHK,
		OP_UNL_RD,
		OP_UNL_WR,
		OP_WALK_RD,
		OP_WALK_CHK,
		OP_FIX_RD,
		OP_FIX_WR,
		OP_FIX_NIL,
		OP_MERGE,
		OP_MERGE_ORD,
		OP_PUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t          op;
		logic            fin;   // finish item this cycle
		logic [ST_W-1:0] res;   // status of the finished item
		logic            blk;   // report the allocated page
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic too_big;
		logic cur_end;
		logic head_valid;
		logic i_done;
		logic free_bad;
		logic top;
		logic bud_ok;
		logic head_is_bud;
		logic walk_end;
		logic nx_is_bud;
	} dp_stat_t;

endpackage

@@ hw/rtl/bpa_dp.sv @@
module bpa_dp #(
	parameter int NUM_ORDERS      = bpa_pkg::NUM_ORDERS_DEF,
	parameter int PAGE_BYTES_LOG2 = bpa_pkg::PAGE_BYTES_LOG2_DEF,
	parameter int HEADER_BYTES    = bpa_pkg::HEADER_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bpa_pkg::dp_cmd_t             cmd,
	output bpa_pkg::dp_stat_t            stat,
	input  logic [bpa_pkg::REQ_W-1:0]    request_bytes,
	input  logic [bpa_pkg::PIDX_W-1:0]   page_index,
	output logic                         done,
	output logic [bpa_pkg::ST_W-1:0]     status,
	output logic [bpa_pkg::PIDX_W-1:0]   block_page
);
	import bpa_pkg::*;

	localparam int PW   = NUM_ORDERS - 1;
	localparam int POOL = 1 << PW;
	localparam int LW   = PW + 1;
	localparam int OW   = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
	localparam int CW   = $clog2(NUM_ORDERS + 1);
	localparam int TOP  = NUM_ORDERS - 1;
	localparam int TW   = REQ_W + 1;
	localparam logic [LW-1:0] NIL = LW'(POOL);

	// Free list heads, link memory, page header memory {allocated, order}
	logic [LW-1:0]    heads_q [NUM_ORDERS];
	logic [LW-1:0]    link_mem [POOL];
	logic [ORD_W:0]   meta_mem [POOL];
	logic [LW-1:0]    link_rd_q;
	logic [ORD_W:0]   meta_rd_q;

	logic [CW-1:0]    want_q, cur_q, i_q;
	logic [PW-1:0]    blk_q, pg_q, bud_q, clr_q;
	logic [ORD_W-1:0] ord_q;
	logic [LW-1:0]    walk_q, steps_q;
	logic             range_ok_q;
	logic             done_q;
	logic [ST_W-1:0]  status_q;
	logic [PIDX_W-1:0] block_q;

	logic [TW-1:0]    total;
	logic [CW-1:0]    want_c;
	logic [CW-1:0]    hsel_w;
	logic [OW-1:0]    h_idx;
	logic [LW-1:0]    head_sel;
	logic             heads_we;
	logic [LW-1:0]    heads_wd;
	logic             link_we, link_re;
	logic [PW-1:0]    link_wa, link_ra;
	logic [LW-1:0]    link_wd;
	logic             meta_we, meta_re;
	logic [PW-1:0]    meta_wa, meta_ra;
	logic [ORD_W:0]   meta_wd;
	logic [PW-1:0]    half, bud_c, lo_c, hi_c;
	logic             in_range;

	// Smallest order whose block holds the request plus header
	assign total = TW'(request_bytes) + TW'(HEADER_BYTES);
	always_comb begin
		want_c = CW'(NUM_ORDERS);
		for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
			if ((64'(1) << (k + PAGE_BYTES_LOG2)) >= 64'(total))
				want_c = CW'(k);
		end
	end

	assign in_range = 32'(page_index) < 32'(POOL);

	// One head read port, index chosen by operation
	always_comb begin
		unique case (cmd.op)
			OP_SEARCH, OP_POP, OP_POP_WR: hsel_w = cur_q;
			OP_SPLIT:                     hsel_w = i_q;
			default:                      hsel_w = CW'(ord_q);
		endcase
		h_idx = (32'(hsel_w) < NUM_ORDERS) ? hsel_w[OW-1:0] : '0;
	end
	assign head_sel = heads_q[h_idx];

	assign half  = blk_q + (PW'(1) << i_q);
	assign bud_c = pg_q ^ (PW'(1) << ord_q);
	assign lo_c  = (pg_q < bud_q) ? pg_q : bud_q;
	assign hi_c  = (pg_q < bud_q) ? bud_q : pg_q;

	// Status back to the controller
	always_comb begin
		stat.clr_last    = clr_q == PW'(POOL - 1);
		stat.too_big     = want_q == CW'(NUM_ORDERS);
		stat.cur_end     = cur_q == CW'(NUM_ORDERS);
		stat.head_valid  = !head_sel[LW-1];
		stat.i_done      = i_q == cur_q;
		stat.free_bad    = !range_ok_q || !meta_rd_q[ORD_W];
		stat.top         = 32'(ord_q) >= TOP;
		stat.bud_ok      = !meta_rd_q[ORD_W] && (meta_rd_q[ORD_W-1:0] == ord_q);
		stat.head_is_bud = head_sel == {1'b0, bud_q};
		stat.walk_end    = walk_q[LW-1] || (steps_q == LW'(POOL));
		stat.nx_is_bud   = link_rd_q == {1'b0, bud_q};
	end

	// Memory port and head write selection
	always_comb begin
		heads_we = 1'b0;
		heads_wd = head_sel;
		link_we  = 1'b0;
		link_wa  = pg_q;
		link_wd  = NIL;
		link_re  = 1'b0;
		link_ra  = bud_q;
		meta_we  = 1'b0;
		meta_wa  = pg_q;
		meta_wd  = '0;
		meta_re  = 1'b0;
		meta_ra  = bud_c;
		unique case (cmd.op)
			OP_CLEAR: begin
				meta_we = 1'b1;
				meta_wa = clr_q;
				meta_wd = (clr_q == '0) ? {1'b0, ORD_W'(TOP)} : '0;
				link_we = clr_q == '0;
				link_wa = '0;
				link_wd = NIL;
			end
			OP_LOAD: begin
				meta_re = 1'b1;
				meta_ra = PW'(page_index);
			end
			OP_POP: begin
				link_re = 1'b1;
				link_ra = head_sel[PW-1:0];
			end
			OP_POP_WR: begin
				heads_we = 1'b1;
				heads_wd = link_rd_q;
				link_we  = 1'b1;
				link_wa  = blk_q;
				link_wd  = NIL;
				meta_we  = 1'b1;
				meta_wa  = blk_q;
				meta_wd  = {1'b1, ORD_W'(want_q)};
			end
			OP_SPLIT: begin
				if (!stat.i_done) begin
					meta_we  = 1'b1;
					meta_wa  = half;
					meta_wd  = {1'b0, ORD_W'(i_q)};
					link_we  = 1'b1;
					link_wa  = half;
					link_wd  = head_sel;
					heads_we = 1'b1;
					heads_wd = {1'b0, half};
				end
			end
			OP_FREE_CHK: begin
				if (!stat.free_bad) begin
					meta_we = 1'b1;
					meta_wa = pg_q;
					meta_wd = {1'b0, meta_rd_q[ORD_W-1:0]};
				end
			end
			OP_BUD_RD: begin
				meta_re = 1'b1;
				meta_ra = bud_c;
			end
			OP_UNL_RD, OP_FIX_RD: begin
				link_re = 1'b1;
				link_ra = bud_q;
			end
			OP_UNL_WR: begin
				heads_we = 1'b1;
				heads_wd = link_rd_q;
				link_we  = 1'b1;
				link_wa  = bud_q;
				link_wd  = NIL;
			end
			OP_WALK_RD: begin
				link_re = 1'b1;
				link_ra = walk_q[PW-1:0];
			end
			OP_FIX_WR: begin
				link_we = 1'b1;
				link_wa = walk_q[PW-1:0];
				link_wd = link_rd_q;
			end
			OP_FIX_NIL: begin
				link_we = 1'b1;
				link_wa = bud_q;
				link_wd = NIL;
			end
			OP_MERGE: begin
				meta_we = 1'b1;
				meta_wa = hi_c;
				meta_wd = '0;
				link_we = 1'b1;
				link_wa = hi_c;
				link_wd = '0;
			end
			OP_MERGE_ORD: begin
				meta_we = 1'b1;
				meta_wa = pg_q;
				meta_wd = {1'b0, ord_q};
			end
			OP_PUSH: begin
				link_we  = 1'b1;
				link_wa  = pg_q;
				link_wd  = head_sel;
				heads_we = 1'b1;
				heads_wd = {1'b0, pg_q};
			end
			default: begin
			end
		endcase
	end

	// Memories, registered read
	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_wa] <= link_wd;
		if (link_re)
			link_rd_q <= link_mem[link_ra];
	end

	always_ff @(posedge clk) begin
		if (meta_we)
			meta_mem[meta_wa] <= meta_wd;
		if (meta_re)
			meta_rd_q <= meta_mem[meta_ra];
	end

	// Free list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_ORDERS; j++)
				heads_q[j] <= (j == TOP) ? '0 : NIL;
		end else if (heads_we) begin
			heads_q[h_idx] <= heads_wd;
		end
	end

	// Control registers: clear sweep and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLEAR)
				clr_q <= clr_q + PW'(1);
			done_q <= cmd.fin;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				want_q     <= want_c;
				cur_q      <= want_c;
				pg_q       <= PW'(page_index);
				range_ok_q <= in_range;
			end
			OP_SEARCH: begin
				if (!stat.too_big && !stat.cur_end && !stat.head_valid)
					cur_q <= cur_q + CW'(1);
			end
			OP_POP:      blk_q <= head_sel[PW-1:0];
			OP_POP_WR:   i_q <= want_q;
			OP_SPLIT: begin
				if (!stat.i_done)
					i_q <= i_q + CW'(1);
			end
			OP_FREE_CHK: ord_q <= meta_rd_q[ORD_W-1:0];
			OP_BUD_RD:   bud_q <= bud_c;
			OP_BUD_CHK: begin
				walk_q  <= head_sel;
				steps_q <= '0;
			end
			OP_WALK_CHK: begin
				if (!stat.nx_is_bud) begin
					walk_q  <= link_rd_q;
					steps_q <= steps_q + LW'(1);
				end
			end
			OP_MERGE: begin
				pg_q  <= lo_c;
				ord_q <= ord_q + ORD_W'(1);
			end
			default: begin
			end
		endcase
		if (cmd.fin) begin
			status_q <= cmd.res;
			block_q  <= cmd.blk ? PIDX_W'(blk_q) : '0;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign block_page = block_q;

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
module bpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               kind,
	output logic               busy,
	output bpa_pkg::dp_cmd_t   cmd,
	input  bpa_pkg::dp_stat_t  stat
);
	import bpa_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_POP,
		S_POP_WR,
		S_SPLIT,
		S_FREE_CHK,
		S_BUD_RD,
		S_BUD_CHK,
		S_UNL_RD,
		S_UNL_WR,
		S_WALK_RD,
		S_WALK_CHK,
		S_FIX_RD,
		S_FIX_WR,
		S_FIX_NIL,
		S_MERGE,
		S_MERGE_ORD,
		S_PUSH
	} state_t;

	state_t state_q, state_d;

	// Next state and command
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NOP;
		cmd.fin = 1'b0;
		cmd.res = ST_OK;
		cmd.blk = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = kind ? S_FREE_CHK : S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.op = OP_SEARCH;
				if (stat.too_big || stat.cur_end) begin
					cmd.fin = 1'b1;
					cmd.res = ST_NOMEM;
					state_d = S_IDLE;
				end else if (stat.head_valid) begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				cmd.op  = OP_POP;
				state_d = S_POP_WR;
			end
			S_POP_WR: begin
				cmd.op  = OP_POP_WR;
				state_d = S_SPLIT;
			end
			S_SPLIT: begin
				cmd.op = OP_SPLIT;
				if (stat.i_done) begin
					cmd.fin = 1'b1;
					cmd.blk = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FREE_CHK: begin
				cmd.op = OP_FREE_CHK;
				if (stat.free_bad) begin
					cmd.fin = 1'b1;
					cmd.res = ST_BADFREE;
					state_d = S_IDLE;
				end else begin
					state_d = S_BUD_RD;
				end
			end
			S_BUD_RD: begin
				cmd.op  = OP_BUD_RD;
				state_d = stat.top ? S_PUSH : S_BUD_CHK;
			end
			S_BUD_CHK: begin
				cmd.op = OP_BUD_CHK;
				priority if (!stat.bud_ok)
					state_d = S_PUSH;
				else if (stat.head_is_bud)
					state_d = S_UNL_RD;
				else
					state_d = S_WALK_RD;
			end
			S_UNL_RD: begin
				cmd.op  = OP_UNL_RD;
				state_d = S_UNL_WR;
			end
			S_UNL_WR: begin
				cmd.op  = OP_UNL_WR;
				state_d = S_MERGE;
			end
			S_WALK_RD: begin
				cmd.op  = OP_WALK_RD;
				state_d = stat.walk_end ? S_MERGE : S_WALK_CHK;
			end
			S_WALK_CHK: begin
				cmd.op  = OP_WALK_CHK;
				state_d = stat.nx_is_bud ? S_FIX_RD : S_WALK_RD;
			end
			S_FIX_RD: begin
				cmd.op  = OP_FIX_RD;
				state_d = S_FIX_WR;
			end
			S_FIX_WR: begin
				cmd.op  = OP_FIX_WR;
				state_d = S_FIX_NIL;
			end
			S_FIX_NIL: begin
				cmd.op  = OP_FIX_NIL;
				state_d = S_MERGE;
			end
			S_MERGE: begin
				cmd.op  = OP_MERGE;
				state_d = S_MERGE_ORD;
			end
			S_MERGE_ORD: begin
				cmd.op  = OP_MERGE_ORD;
				state_d = S_BUD_RD;
			end
			S_PUSH: begin
				cmd.op  = OP_PUSH;
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	assign busy = state_q != S_IDLE;

endmodule

@@ hw/rtl/buddy_page_allocator_top.sv @@
// Channel  Handshake             Payload
// request  start & !busy         kind, request_bytes, page_index
// result   done (one cycle)      status, block_page
//
// One item in flight; busy is high from acceptance to the last work cycle, done
// follows in the cycle after it. Allocate: search lists up from the wanted
// order, pop a head, split it down. Free: check the page header, then try a
// buddy merge per level, unlinking the buddy from its list head or via a walk;
// an invalid free ends at the check. Results cannot be held off. After reset,
// a pass with busy high clears 2^(NUM_ORDERS-1) page headers (1024 by default).
module buddy_page_allocator_top #(
	parameter int NUM_ORDERS      = bpa_pkg::NUM_ORDERS_DEF,
	parameter int PAGE_BYTES_LOG2 = bpa_pkg::PAGE_BYTES_LOG2_DEF,
	parameter int HEADER_BYTES    = bpa_pkg::HEADER_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        kind,
	input  logic [bpa_pkg::REQ_W-1:0]   request_bytes,
	input  logic [bpa_pkg::PIDX_W-1:0]  page_index,
	output logic                        done,
	output logic [bpa_pkg::ST_W-1:0]    status,
	output logic [bpa_pkg::PIDX_W-1:0]  block_page
);
	import bpa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	bpa_dp #(
		.NUM_ORDERS      (NUM_ORDERS),
		.PAGE_BYTES_LOG2 (PAGE_BYTES_LOG2),
		.HEADER_BYTES    (HEADER_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.request_bytes (request_bytes),
		.page_index    (page_index),
		.done          (done),
		.status        (status),
		.block_page    (block_page)
	);

	// A result only follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in progress");

	// An accepted item occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// Status codes stay in range
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_NOMEM || status == ST_BADFREE))
		else $error("bad status code");

	// Failed requests report page zero
	a_fail_page: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> block_page == '0)
		else $error("page reported on failure");

endmodule
